/* rtl/core/kls_pkg.sv */
package kls_pkg;

    localparam int MaxFramesDefault = 64;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int FrameW = 32 + 16 * 3 + 8 + 32;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        key_time;
        logic signed [15:0] throttle_in;
        logic signed [15:0] brake_in;
        logic signed [15:0] steering_in;
        logic signed [7:0]  gear_in;
        logic [31:0]        buttons_in;
        logic [15:0]        delta_time;
    } t_in_word;

    typedef struct packed {
        logic               connected;
        logic signed [15:0] throttle_out;
        logic signed [15:0] brake_out;
        logic signed [15:0] steering_out;
        logic signed [7:0]  gear_out;
        logic [31:0]        buttons_out;
        logic [1:0]         load_status;
    } t_out_word;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [15:0] thr;
        logic signed [15:0] brk;
        logic signed [15:0] str;
        logic signed [7:0]  gear;
        logic [31:0]        btn;
    } t_frame;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_rsp;

endpackage

/* rtl/core/kls_ram.sv */
module kls_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/kls_div.sv */
// restoring divider: floor(num * 65536 / den), num < den, one bit a cycle
module kls_div
    import kls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_quot;
    logic        r_done;
    logic [33:0] n_shift;
    logic [33:0] n_diff;

    assign n_shift = {r_rem, 1'b0};
    assign n_diff  = n_shift - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_req.num};
                r_den  <= i_req.den;
                r_quot <= '0;
            end else if (r_busy) begin
                if (!n_diff[33]) begin
                    r_rem  <= n_diff[32:0];
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem  <= n_shift[32:0];
                    r_quot <= {r_quot[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quot: r_quot};
endmodule

/* rtl/core/kls_lerp.sv */
// one channel a step: a + floor((b - a) * frac / 65536), registered
module kls_lerp
    import kls_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    input  logic [15:0]        i_frac,
    output logic signed [15:0] o_y
);
    logic signed [16:0] n_d;
    logic signed [33:0] n_p;
    logic signed [17:0] n_q;
    logic signed [15:0] r_y;

    always_comb begin
        n_d = 17'(i_b) - 17'(i_a);
        n_p = 34'(n_d) * $signed({18'd0, i_frac});
        n_q = n_p[33:16];
    end

    always_ff @(posedge i_clk) begin
        r_y <= 16'(18'(i_a) + n_q);
    end

    assign o_y = r_y;
endmodule

/* rtl/core/keyframe_lerp_sampler_top.sv */
// keyframe_lerp_sampler_top: piecewise-linear keyframe sampler
// input channel i_in_valid/o_in_ready carries one command word (load, sample,
// clear); output channel o_out_valid/i_out_ready returns one result word for
// each command word.
// a load reads the last entry (S_LOAD_RD) and checks it (S_LOAD) before the
// result is valid; a clear or unused word goes straight to the result. a sample
// reads the keyframe table through one registered ram port, walking it one
// entry a cycle to find the bracket, then, if the clock lies between two
// keyframes, runs a 16-step shift-subtract divider and three passes of one
// shared multiplier before the result is valid.
// the block takes one word at a time: o_in_ready is high only when idle and
// the previous result has been taken.
// reset (synchronous, active low) empties the table, zeros the clock and
// clears the order fault; table contents are not cleared.
// if the receiver stalls, the result is held in the output register and no
// new word is accepted until it is taken.
module keyframe_lerp_sampler_top
    import kls_pkg::*;
#(
    parameter int MAX_FRAMES = MaxFramesDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);
    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD_RD, S_LOAD, S_SMP_RD0, S_SMP_FIRST, S_SMP_SCAN,
        S_SMP_DIV, S_LERP0, S_LERP1, S_LERP2, S_HOLD, S_OUT
    } t_state;

    t_state    r_state;
    t_in_word  r_in;
    t_out_word r_out;
    logic [CW-1:0] r_count;
    logic [31:0]   r_clock;
    logic          r_fault;
    logic [AW-1:0] r_idx;
    t_frame        r_lo;
    t_frame        r_hi;
    logic [15:0]   r_frac;
    logic          r_div_start;

    logic          n_we;
    logic [AW-1:0] n_raddr;
    t_frame        n_wframe;
    t_frame        n_rframe;
    logic [FrameW-1:0] n_rdata;
    logic [32:0]   n_sum;
    t_div_rsp      n_div;
    logic signed [15:0] n_la;
    logic signed [15:0] n_lb;
    logic signed [15:0] n_ly;
    logic [AW-1:0] n_last;

    assign n_last = AW'(r_count - CW'(1));
    assign n_rframe = t_frame'(n_rdata);
    assign n_wframe = '{t: r_in.key_time, thr: r_in.throttle_in, brk: r_in.brake_in,
                        str: r_in.steering_in, gear: r_in.gear_in, btn: r_in.buttons_in};
    assign n_we = (r_state == S_LOAD) && (r_count != CW'(MAX_FRAMES))
               && !((r_count != '0) && (r_in.key_time <= n_rframe.t));
    assign n_sum = {1'b0, r_clock} + {17'd0, r_in.delta_time};

    always_comb begin
        case (r_state)
            S_IDLE:      n_raddr = (i_in_data.action == ACT_LOAD) ? n_last : '0;
            S_LOAD_RD:   n_raddr = n_last;
            S_SMP_FIRST: n_raddr = (r_count == CW'(1)) ? '0 : AW'(1);
            S_SMP_SCAN:  n_raddr = r_idx + AW'(2);
            default:     n_raddr = '0;
        endcase
    end

    kls_ram #(.Width(FrameW), .Depth(MAX_FRAMES)) u_ram (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(AW'(r_count)), .i_wdata(n_wframe),
        .i_raddr(n_raddr), .o_rdata(n_rdata)
    );

    kls_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req('{start: r_div_start, num: r_clock - r_lo.t, den: r_hi.t - r_lo.t}),
        .o_rsp(n_div)
    );

    always_comb begin
        case (r_state)
            S_LERP1: begin n_la = r_lo.brk; n_lb = r_hi.brk; end
            S_LERP2: begin n_la = r_lo.str; n_lb = r_hi.str; end
            default: begin n_la = r_lo.thr; n_lb = r_hi.thr; end
        endcase
    end

    kls_lerp u_lerp (.i_clk(i_clk), .i_a(n_la), .i_b(n_lb), .i_frac(r_frac), .o_y(n_ly));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_clock <= '0;
            r_fault <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_in  <= i_in_data;
                    case (i_in_data.action)
                        ACT_LOAD: begin
                            r_out   <= '0;
                            r_state <= S_LOAD_RD;
                        end
                        ACT_SAMPLE: begin
                            r_out   <= '0;
                            r_state <= S_SMP_RD0;
                        end
                        ACT_CLEAR: begin
                            r_out   <= '0;
                            r_count <= '0;
                            r_clock <= '0;
                            r_fault <= 1'b0;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_out <= '{connected: (r_count != '0) && !r_fault, default: '0};
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_LOAD_RD: r_state <= S_LOAD;
                S_LOAD: begin
                    if (r_count == CW'(MAX_FRAMES)) begin
                        r_out.load_status <= ST_FULL;
                        r_out.connected <= !r_fault;
                    end else if ((r_count != '0) && (r_in.key_time <= n_rframe.t)) begin
                        r_out.load_status <= ST_ORDER;
                        r_fault <= 1'b1;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_out.connected <= !r_fault;
                    end
                    r_state <= S_OUT;
                end
                S_SMP_RD0: begin
                    r_clock <= n_sum[32] ? 32'hFFFF_FFFF : n_sum[31:0];
                    r_idx   <= '0;
                    r_state <= (r_count == '0) ? S_OUT : S_SMP_FIRST;
                end
                S_SMP_FIRST: begin
                    r_lo <= n_rframe;
                    if ((r_clock <= n_rframe.t) || (r_count == CW'(1))) begin
                        r_hi <= n_rframe;
                        r_state <= S_HOLD;
                    end else begin
                        r_state <= S_SMP_SCAN;
                    end
                end
                S_SMP_SCAN: begin
                    if (r_clock < n_rframe.t) begin
                        r_hi <= n_rframe;
                        r_div_start <= 1'b1;
                        r_state <= S_SMP_DIV;
                    end else if (r_idx + AW'(1) == n_last) begin
                        r_lo <= n_rframe;
                        r_hi <= n_rframe;
                        r_state <= S_HOLD;
                    end else begin
                        r_lo  <= n_rframe;
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_SMP_DIV: if (n_div.done) begin
                    r_frac  <= n_div.quot;
                    r_state <= S_LERP0;
                end
                S_LERP0: r_state <= S_LERP1;
                S_LERP1: begin
                    r_out.throttle_out <= n_ly;
                    r_state <= S_LERP2;
                end
                S_LERP2: begin
                    r_out.brake_out <= n_ly;
                    r_frac <= r_frac;
                    r_state <= S_HOLD;
                    r_lo.thr <= r_lo.str;
                    r_hi.thr <= r_hi.str;
                end
                S_HOLD: begin
                    if (r_lo.t == r_hi.t) begin
                        r_out.throttle_out <= r_lo.thr;
                        r_out.brake_out    <= r_lo.brk;
                        r_out.steering_out <= r_lo.str;
                    end else begin
                        r_out.steering_out <= n_ly;
                    end
                    r_out.gear_out    <= r_lo.gear;
                    r_out.buttons_out <= r_lo.btn;
                    r_out.connected   <= !r_fault;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_out_ready) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_SMP_RD0 && r_count == '0) begin
                r_out.connected <= 1'b0;
            end
        end
    end
endmodule

/* rtl/core/kls_checker.sv */
module kls_checker
    import kls_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.action == ACT_CLEAR |=>
        o_out_valid && !o_out_data.connected) else $error("clear result");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.load_status != 2'd3) else $error("bad status");
endmodule

bind keyframe_lerp_sampler_top kls_checker u_kls_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .i_in_data(i_in_data), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_out_data(o_out_data)
);

/* tb/tb_keyframe_lerp_sampler_top.sv */
`timescale 1ns / 1ps

module tb_keyframe_lerp_sampler_top;
    import kls_pkg::*;

    localparam int NFRAMES = 64;
    localparam int WDOG_LIMIT = 20000;

    class lerp_scoreboard;
        logic [31:0]        kt[NFRAMES];
        logic signed [15:0] kthr[NFRAMES];
        logic signed [15:0] kbrk[NFRAMES];
        logic signed [15:0] kstr[NFRAMES];
        logic signed [7:0]  kgear[NFRAMES];
        logic [31:0]        kbtn[NFRAMES];
        int unsigned        count;
        logic [31:0]        clk_ticks;
        bit                 fault;
        t_out_word          pending[$];
        int                 errors;
        int                 checked;

        function void clear_state();
            count = 0;
            clk_ticks = 0;
            fault = 0;
        endfunction

        function logic signed [15:0] lerp(logic signed [15:0] a, logic signed [15:0] b,
                                          logic [15:0] frac);
            logic signed [63:0] p;
            p = (64'(b) - 64'(a)) * $signed({48'd0, frac});
            return 16'(64'(a) + (p >>> 16));
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            logic [32:0] sum;
            int unsigned i, last;
            logic [47:0] num;
            logic [31:0] span;
            logic [47:0] q;
            logic [15:0] frac;
            r = '0;
            case (t_action'(w.action))
                ACT_LOAD: begin
                    if (count >= NFRAMES) begin
                        r.load_status = ST_FULL;
                    end else if (count > 0 && w.key_time <= kt[count-1]) begin
                        r.load_status = ST_ORDER;
                        fault = 1;
                    end else begin
                        kt[count] = w.key_time;
                        kthr[count] = w.throttle_in;
                        kbrk[count] = w.brake_in;
                        kstr[count] = w.steering_in;
                        kgear[count] = w.gear_in;
                        kbtn[count] = w.buttons_in;
                        count++;
                    end
                end
                ACT_SAMPLE: begin
                    sum = {1'b0, clk_ticks} + {17'd0, w.delta_time};
                    clk_ticks = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (count > 0) begin
                        last = count - 1;
                        if (clk_ticks <= kt[0] || clk_ticks >= kt[last]) begin
                            i = (clk_ticks <= kt[0]) ? 0 : last;
                            r.throttle_out = kthr[i];
                            r.brake_out = kbrk[i];
                            r.steering_out = kstr[i];
                            r.gear_out = kgear[i];
                            r.buttons_out = kbtn[i];
                        end else begin
                            i = 0;
                            while (i + 1 < last && clk_ticks >= kt[i+1]) i++;
                            span = kt[i+1] - kt[i];
                            num = {16'd0, clk_ticks - kt[i]} << 16;
                            q = (span != 0) ? num / span : 0;
                            frac = (q > 65535) ? 16'hFFFF : q[15:0];
                            r.throttle_out = lerp(kthr[i], kthr[i+1], frac);
                            r.brake_out = lerp(kbrk[i], kbrk[i+1], frac);
                            r.steering_out = lerp(kstr[i], kstr[i+1], frac);
                            r.gear_out = kgear[i];
                            r.buttons_out = kbtn[i];
                        end
                    end
                end
                ACT_CLEAR: clear_state();
                default: ;
            endcase
            r.connected = (count > 0) && !fault;
            pending.insert(pending.size(), r);
        endfunction

        function void check_word(t_out_word a);
            t_out_word e;
            checked++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.connected !== e.connected) begin
                $error("connected exp %0d got %0d", e.connected, a.connected); errors++;
            end
            if (a.throttle_out !== e.throttle_out) begin
                $error("throttle_out exp %0d got %0d", e.throttle_out, a.throttle_out);
                errors++;
            end
            if (a.brake_out !== e.brake_out) begin
                $error("brake_out exp %0d got %0d", e.brake_out, a.brake_out); errors++;
            end
            if (a.steering_out !== e.steering_out) begin
                $error("steering_out exp %0d got %0d", e.steering_out, a.steering_out);
                errors++;
            end
            if (a.gear_out !== e.gear_out) begin
                $error("gear_out exp %0d got %0d", e.gear_out, a.gear_out); errors++;
            end
            if (a.buttons_out !== e.buttons_out) begin
                $error("buttons_out exp %h got %h", e.buttons_out, a.buttons_out); errors++;
            end
            if (a.load_status !== e.load_status) begin
                $error("load_status exp %0d got %0d", e.load_status, a.load_status); errors++;
            end
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_ready;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 0;
    t_out_word o_out_data;

    lerp_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    int stall_cycles;
    int n_loads, n_samples, n_clears;
    logic [31:0] next_time;

    always #5 i_clk = ~i_clk;

    keyframe_lerp_sampler_top dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_word(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_word(o_out_data);
        if (i_rst_n && !((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_data <= w;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (t_action'(w.action))
            ACT_LOAD: n_loads++;
            ACT_SAMPLE: n_samples++;
            ACT_CLEAR: n_clears++;
            default: ;
        endcase
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(t_in_word)-1:0];
        return w;
    endfunction

    task automatic send_load(logic [31:0] t);
        t_in_word w;
        w = rand_word();
        w.action = ACT_LOAD;
        w.key_time = t;
        send_word(w);
    endtask

    task automatic send_sample(logic [15:0] dt);
        t_in_word w;
        w = rand_word();
        w.action = ACT_SAMPLE;
        w.delta_time = dt;
        send_word(w);
    endtask

    task automatic send_clear();
        t_in_word w;
        w = rand_word();
        w.action = ACT_CLEAR;
        send_word(w);
    endtask

    task automatic run_random(int n_items);
        int k, nf, r;
        t_in_word w;
        k = 0;
        while (k < n_items) begin
            send_clear(); k++;
            nf = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 6);
            next_time = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000);
            for (int j = 0; j < nf; j++) begin
                r = $urandom_range(19);
                if (r == 0) send_load(next_time - $urandom_range(3));
                else begin
                    send_load(next_time);
                    if ($urandom_range(7) == 0) next_time += 1;
                    else if ($urandom_range(9) == 0) next_time += $urandom;
                    else next_time += $urandom_range(1, 3000);
                end
                k++;
            end
            repeat ($urandom_range(4, 16)) begin
                r = $urandom_range(19);
                if (r == 0) begin
                    w = rand_word(); w.action = ACT_NONE; send_word(w);
                end else if (r == 1) send_sample(16'($urandom));
                else send_sample(16'($urandom_range(1200)));
                k++;
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        send_idle_pct = 11;
        recv_idle_pct = 78;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        send_sample(16'hFFFF);
        send_load(32'd100);
        send_sample(16'd0);
        send_load(32'd100);
        send_sample(16'd50);
        send_clear();
        begin
            t_in_word w;
            w = '1; w.action = ACT_LOAD; w.key_time = 32'd10; send_word(w);
            w = '0; w.action = ACT_LOAD; w.key_time = 32'd20;
            w.throttle_in = 16'sh8000; w.brake_in = 16'sh8000; w.steering_in = 16'sh8000;
            w.gear_in = 8'sh80; send_word(w);
            w = '1; w.action = ACT_LOAD; w.key_time = 32'hFFFF_FFFF; send_word(w);
            w = '1; w.action = ACT_NONE; send_word(w);
        end
        send_sample(16'd15);
        send_sample(16'd4);
        send_sample(16'hFFFF);
        repeat (6) send_sample(16'hFFFF);
        send_clear();
        for (int j = 0; j < 65; j++) send_load(32'(j * 7));
        send_sample(16'd200);

        run_random(570);
        send_idle_pct = 78; recv_idle_pct = 11;
        run_random(570);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(570);
        @(negedge i_clk);
        i_in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d loads, %0d samples, %0d clears; %0d result words checked",
                 n_loads, n_samples, n_clears, sb.checked);
        $display("idle mixes: sender/receiver 11/78, 78/11 and 0/0 percent");
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
